[hw/rtl/nbsf_pkg.sv]
package nbsf_pkg;

    localparam int unsigned DATA_W      = 8;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned LEN_CFG_W   = 4;
    localparam int unsigned PAT_BYTES   = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OCCURRENCE_WANTED = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } s_item_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] match_offset;
    } m_item_t;

    typedef struct packed {
        logic advance;
        logic flush;
    } win_ctl_t;

endpackage

[hw/rtl/nbsf_matcher.sv]
module nbsf_matcher
    import nbsf_pkg::*;
#(
    parameter int unsigned WIN_BYTES = 8,
    parameter int unsigned LEN_W     = $clog2(WIN_BYTES + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  win_ctl_t                    ctl,
    input  logic [DATA_W-1:0]           data_byte,
    input  logic [WIN_BYTES*DATA_W-1:0] pattern,
    input  logic [LEN_W-1:0]            length,
    output logic                        hit
);

    logic [DATA_W-1:0] win_reg  [WIN_BYTES];
    logic [DATA_W-1:0] win_next [WIN_BYTES];
    logic [WIN_BYTES:0] eq_len;

    always_comb begin
        win_next[WIN_BYTES-1] = data_byte;
        for (int k = 0; k < WIN_BYTES - 1; k++) begin
            win_next[k] = win_reg[k+1];
        end
    end

    // compare the newest bytes against the pattern, one candidate per length
    always_comb begin
        eq_len[0] = 1'b0;
        for (int l = 1; l <= WIN_BYTES; l++) begin
            eq_len[l] = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (win_next[WIN_BYTES-l+j] != pattern[j*DATA_W +: DATA_W]) begin
                    eq_len[l] = 1'b0;
                end
            end
        end
    end

    assign hit = eq_len[length];

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.flush) begin
            for (int k = 0; k < WIN_BYTES; k++) begin
                win_reg[k] <= '0;
            end
        end else if (ctl.advance) begin
            win_reg <= win_next;
        end
    end

endmodule

[hw/rtl/nth_byte_sequence_finder_top.sv]
// channel   ports                      item      accepted when
// input     s_valid s_ready s_item     s_item_t  s_valid && s_ready
// result    m_valid m_ready m_item     m_item_t  m_valid && m_ready
// config    cfg_we cfg_index cfg_wdata -         cfg_we high
// One byte per cycle while s_ready: window compare and counter update finish in the
// accepting cycle; a result shows on m_valid the next cycle unless one is waiting.
// A two-entry result queue (output register plus skid entry) lets input flow
// while one result is stalled; s_ready drops only while both entries are full.
// aresetn is synchronous, active low; it clears stream state and config, but length resets to 1.
module nth_byte_sequence_finder_top
    import nbsf_pkg::*;
#(
    parameter int unsigned MAX_PATTERN_BYTES = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  s_item_t                s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output m_item_t                m_item
);

    localparam int unsigned WIN_BYTES = (MAX_PATTERN_BYTES < PAT_BYTES) ?
                                        MAX_PATTERN_BYTES : PAT_BYTES;
    localparam int unsigned LEN_W     = $clog2(WIN_BYTES + 1);
    localparam logic [LEN_CFG_W-1:0] LEN_LIM = LEN_CFG_W'(WIN_BYTES);

    logic [CFG_DATA_W-1:0] pattern_reg;
    logic [LEN_CFG_W-1:0]  length_reg;
    logic [COUNT_W-1:0]    occurrence_reg;

    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] matches_seen_reg;
    logic               reported_reg;

    m_item_t out_reg;
    logic    out_valid_reg;
    m_item_t skid_reg;
    logic    skid_valid_reg;

    logic               accept;
    logic               pop;
    logic               hit;
    logic               armed;
    logic               take;
    logic               res_valid;
    logic [LEN_CFG_W-1:0] len_act;
    logic [COUNT_W-1:0] count_next;
    m_item_t            res;
    win_ctl_t           win_ctl;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;
    assign pop     = out_valid_reg && m_ready;

    always_comb begin
        if (length_reg == '0) begin
            len_act = LEN_CFG_W'(1);
        end else if (length_reg > LEN_LIM) begin
            len_act = LEN_LIM;
        end else begin
            len_act = length_reg;
        end
    end

    assign win_ctl.advance = accept;
    assign win_ctl.flush   = accept && s_item.last_byte;

    nbsf_matcher #(
        .WIN_BYTES (WIN_BYTES),
        .LEN_W     (LEN_W)
    ) u_matcher (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (win_ctl),
        .data_byte (s_item.data_byte),
        .pattern   (pattern_reg[WIN_BYTES*DATA_W-1:0]),
        .length    (len_act[LEN_W-1:0]),
        .hit       (hit)
    );

    always_comb begin
        count_next = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                   : byte_count_reg + COUNT_W'(1);
        armed      = !reported_reg && (count_next >= COUNT_W'(len_act)) && hit;
        take       = armed && (matches_seen_reg == occurrence_reg);
        res_valid  = take || (s_item.last_byte && !reported_reg);
        res.found        = take;
        res.match_offset = take ? (count_next - COUNT_W'(len_act)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg    <= '0;
            length_reg     <= LEN_CFG_W'(1);
            occurrence_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PATTERN_BYTES:     pattern_reg    <= cfg_wdata;
                CFG_PATTERN_LENGTH:    length_reg     <= cfg_wdata[LEN_CFG_W-1:0];
                CFG_OCCURRENCE_WANTED: occurrence_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            matches_seen_reg <= '0;
            reported_reg     <= 1'b0;
        end else if (accept) begin
            if (s_item.last_byte) begin
                byte_count_reg   <= '0;
                matches_seen_reg <= '0;
                reported_reg     <= 1'b0;
            end else begin
                byte_count_reg <= count_next;
                if (take) begin
                    reported_reg <= 1'b1;
                end else if (armed && matches_seen_reg != COUNT_MAX) begin
                    matches_seen_reg <= matches_seen_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept && res_valid) begin
            if (!out_valid_reg || pop) begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_stream_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.last_byte |=> byte_count_reg == '0 && !reported_reg)
        else $error("stream state not cleared after final item");

    a_not_found_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.found |-> m_item.match_offset == '0)
        else $error("not-found result carries an offset");

    a_reported_needs_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        reported_reg |-> byte_count_reg != '0)
        else $error("match reported with no bytes counted");

endmodule
